// File: design/dhs_pkg.sv
package dhs_pkg;

    localparam int CYL_W  = 16;
    localparam int DC_W   = 17;
    localparam int SUM_W  = 22;
    localparam int CIDX_W = 2;

    localparam logic [1:0] ALG_FCFS = 2'd0;
    localparam logic [1:0] ALG_SSTF = 2'd1;
    localparam logic [1:0] ALG_SCAN = 2'd2;

    localparam logic [CIDX_W-1:0] REG_ALGORITHM  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_START_HEAD = 2'd1;
    localparam logic [CIDX_W-1:0] REG_DISK_CYL   = 2'd2;
    localparam logic [CIDX_W-1:0] REG_SCAN_DIR   = 2'd3;

endpackage

// File: design/disk_head_scheduler.sv
// Disk arm scheduler (FCFS, SSTF, SCAN).
// Input channel: an item (cylinder, last_request) is taken when start is high
// and busy is low, one item per cycle while a batch is being collected. Items
// beyond MAX_REQUESTS are dropped; an item flagged last_request closes the
// batch and busy rises until the final stop has been presented.
// Result channel: each stop shows for one cycle with result_valid high; the
// receiver cannot stall it. last_stop marks the final stop of a batch.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index selects the
// register, cfg_data carries the value; write only while busy is low.
// Storage: requests live in a synchronous RAM (one write, one read port). FCFS
// reads each request in a read state (S_FRD) and then emits it (S_FEM). SSTF and
// SCAN sweep the whole batch for every stop; SCAN adds one sweep for the
// disk-end stop. Each RAM word carries a served mark next to the cylinder;
// storing a request clears it, serving it in SSTF or SCAN sets it.
// Reset: registers return to algorithm FCFS, start head 0, 200 cylinders,
// upward scan; the request count is zero and no batch is pending.
module disk_head_scheduler #(
    parameter int MAX_REQUESTS  = 63,
    parameter int CYLINDER_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [dhs_pkg::CYL_W-1:0]   cylinder,
    input  logic                        last_request,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dhs_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [dhs_pkg::DC_W-1:0]    cfg_data,
    output logic                        result_valid,
    output logic [dhs_pkg::CYL_W-1:0]   served_cylinder,
    output logic [dhs_pkg::CYL_W-1:0]   seek_distance,
    output logic [dhs_pkg::SUM_W-1:0]   total_movement,
    output logic                        is_turnaround,
    output logic                        last_stop
);

    localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int SW = CW + 1;
    localparam int CB = CYLINDER_BITS;
    localparam logic [CB-1:0] CYL_MAX = '1;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_REQUESTS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FRD   = 2'd1;
    localparam logic [1:0] S_FEM   = 2'd2;
    localparam logic [1:0] S_SWEEP = 2'd3;

    localparam logic [1:0] P_SSTF   = 2'd0;
    localparam logic [1:0] P_FIRST  = 2'd1;
    localparam logic [1:0] P_SECOND = 2'd2;

    logic [1:0]                 alg_reg;
    logic [dhs_pkg::CYL_W-1:0]  start_head_reg;
    logic [dhs_pkg::DC_W-1:0]   disk_cyl_reg;
    logic                       scan_dir_reg;

    // word: {served mark, cylinder}
    logic [CB:0]                mem [MAX_REQUESTS];
    logic [CB:0]                rd_data_reg;
    logic [AW-1:0]              rd_addr;
    logic [CB-1:0]              rd_cyl;
    logic                       rd_served;
    logic                       mark_en;

    logic [1:0]                 state_reg;
    logic [1:0]                 phase_reg;
    logic                       dir_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              issue_reg;
    logic                       dv_reg;
    logic [AW-1:0]              didx_reg;
    logic                       found_reg;
    logic [CB-1:0]              best_key_reg;
    logic [CB-1:0]              best_val_reg;
    logic [AW-1:0]              best_idx_reg;
    logic [CB-1:0]              head_reg;
    logic [CB-1:0]              pivot_reg;
    logic [dhs_pkg::SUM_W-1:0]  sum_reg;
    logic [SW-1:0]              stop_cnt_reg;
    logic [SW-1:0]              total_reg;

    logic                       res_valid_reg;
    logic [dhs_pkg::CYL_W-1:0]  res_cyl_reg;
    logic [dhs_pkg::CYL_W-1:0]  res_dist_reg;
    logic [dhs_pkg::SUM_W-1:0]  res_sum_reg;
    logic                       res_turn_reg;
    logic                       res_last_reg;

    logic [dhs_pkg::DC_W-1:0]   top_m1;
    logic [CB-1:0]              top_end;
    logic [CB-1:0]              diff;
    logic                       side_up;
    logic                       elig;
    logic [CB-1:0]              key;
    logic                       take;
    logic                       sweep_done;
    logic                       emit_en;
    logic [CB-1:0]              emit_tgt;
    logic                       emit_turn;
    logic [CB-1:0]              emit_dist;
    logic                       emit_last;
    logic                       accept;
    logic [CW-1:0]              cnt_after;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign cnt_after = (count_reg < CNT_MAX) ? count_reg + 1'b1 : count_reg;

    assign rd_cyl    = rd_data_reg[CB-1:0];
    assign rd_served = rd_data_reg[CB];

    assign result_valid    = res_valid_reg;
    assign served_cylinder = res_cyl_reg;
    assign seek_distance   = res_dist_reg;
    assign total_movement  = res_sum_reg;
    assign is_turnaround   = res_turn_reg;
    assign last_stop       = res_last_reg;

    always_comb
    begin
        top_m1 = (disk_cyl_reg == '0) ? '0 : disk_cyl_reg - 1'b1;
        if (top_m1 > dhs_pkg::DC_W'(CYL_MAX))
            top_end = CYL_MAX;
        else
            top_end = top_m1[CB-1:0];

        diff    = (rd_cyl >= head_reg) ? rd_cyl - head_reg : head_reg - rd_cyl;
        side_up = (phase_reg == P_FIRST) ? dir_reg : !dir_reg;
        if (phase_reg == P_SSTF)
        begin
            elig = 1'b1;
            key  = diff;
        end
        else if (side_up)
        begin
            elig = rd_cyl > pivot_reg;
            key  = rd_cyl;
        end
        else
        begin
            elig = rd_cyl <= pivot_reg;
            key  = ~rd_cyl;
        end
        take = dv_reg && elig && !rd_served && (!found_reg || key < best_key_reg);

        sweep_done = (state_reg == S_SWEEP) && (issue_reg == count_reg) && !dv_reg;
        mark_en    = sweep_done && found_reg;
        rd_addr    = (state_reg == S_SWEEP) ? issue_reg[AW-1:0] : stop_cnt_reg[AW-1:0];

        emit_en   = 1'b0;
        emit_tgt  = rd_cyl;
        emit_turn = 1'b0;
        if (state_reg == S_FEM)
            emit_en = 1'b1;
        else if (sweep_done && found_reg)
        begin
            emit_en  = 1'b1;
            emit_tgt = best_val_reg;
        end
        else if (sweep_done && phase_reg == P_FIRST)
        begin
            emit_en   = 1'b1;
            emit_turn = 1'b1;
            emit_tgt  = dir_reg ? top_end : '0;
        end
        emit_dist = (emit_tgt >= head_reg) ? emit_tgt - head_reg : head_reg - emit_tgt;
        emit_last = (stop_cnt_reg + 1'b1 == total_reg);
    end

    // stores happen only while idle, served marks only during a sweep
    always_ff @(posedge clk)
    begin
        if (accept && count_reg < CNT_MAX)
            mem[count_reg[AW-1:0]] <= {1'b0, cylinder[CB-1:0]};
        else if (mark_en)
            mem[best_idx_reg] <= {1'b1, best_val_reg};
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alg_reg        <= dhs_pkg::ALG_FCFS;
            start_head_reg <= '0;
            disk_cyl_reg   <= dhs_pkg::DC_W'(200);
            scan_dir_reg   <= 1'b1;
            state_reg      <= S_IDLE;
            phase_reg      <= P_SSTF;
            dir_reg        <= 1'b1;
            count_reg      <= '0;
            issue_reg      <= '0;
            dv_reg         <= 1'b0;
            didx_reg       <= '0;
            found_reg      <= 1'b0;
            best_key_reg   <= '0;
            best_val_reg   <= '0;
            best_idx_reg   <= '0;
            head_reg       <= '0;
            pivot_reg      <= '0;
            sum_reg        <= '0;
            stop_cnt_reg   <= '0;
            total_reg      <= '0;
            res_valid_reg  <= 1'b0;
            res_cyl_reg    <= '0;
            res_dist_reg   <= '0;
            res_sum_reg    <= '0;
            res_turn_reg   <= 1'b0;
            res_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    dhs_pkg::REG_ALGORITHM:  alg_reg        <= cfg_data[1:0];
                    dhs_pkg::REG_START_HEAD: start_head_reg <= cfg_data[dhs_pkg::CYL_W-1:0];
                    dhs_pkg::REG_DISK_CYL:   disk_cyl_reg   <= cfg_data;
                    dhs_pkg::REG_SCAN_DIR:   scan_dir_reg   <= cfg_data[0];
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg <= cnt_after;
                        if (last_request)
                        begin
                            head_reg     <= start_head_reg[CB-1:0];
                            pivot_reg    <= start_head_reg[CB-1:0];
                            sum_reg      <= '0;
                            stop_cnt_reg <= '0;
                            issue_reg    <= '0;
                            dv_reg       <= 1'b0;
                            found_reg    <= 1'b0;
                            dir_reg      <= scan_dir_reg;
                            if (alg_reg == dhs_pkg::ALG_SCAN)
                            begin
                                phase_reg <= P_FIRST;
                                total_reg <= SW'(cnt_after) + 1'b1;
                                state_reg <= S_SWEEP;
                            end
                            else if (alg_reg == dhs_pkg::ALG_SSTF)
                            begin
                                phase_reg <= P_SSTF;
                                total_reg <= SW'(cnt_after);
                                state_reg <= S_SWEEP;
                            end
                            else
                            begin
                                total_reg <= SW'(cnt_after);
                                state_reg <= S_FRD;
                            end
                        end
                    end
                end
                S_FRD:
                    state_reg <= S_FEM;
                S_FEM:
                    state_reg <= S_FRD;
                S_SWEEP:
                begin
                    dv_reg   <= (issue_reg != count_reg);
                    didx_reg <= issue_reg[AW-1:0];
                    if (issue_reg != count_reg)
                        issue_reg <= issue_reg + 1'b1;
                    if (take)
                    begin
                        found_reg    <= 1'b1;
                        best_key_reg <= key;
                        best_val_reg <= rd_cyl;
                        best_idx_reg <= didx_reg;
                    end
                    if (sweep_done)
                    begin
                        issue_reg <= '0;
                        found_reg <= 1'b0;
                        if (!found_reg)
                        begin
                            if (phase_reg == P_FIRST)
                                phase_reg <= P_SECOND;
                            else
                            begin
                                // nothing left to serve
                                state_reg <= S_IDLE;
                                count_reg <= '0;
                            end
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase

            res_valid_reg <= emit_en;
            if (emit_en)
            begin
                head_reg     <= emit_tgt;
                sum_reg      <= sum_reg + dhs_pkg::SUM_W'(emit_dist);
                stop_cnt_reg <= stop_cnt_reg + 1'b1;
                res_cyl_reg  <= dhs_pkg::CYL_W'(emit_tgt);
                res_dist_reg <= dhs_pkg::CYL_W'(emit_dist);
                res_sum_reg  <= sum_reg + dhs_pkg::SUM_W'(emit_dist);
                res_turn_reg <= emit_turn;
                res_last_reg <= emit_last;
                if (emit_last)
                begin
                    state_reg <= S_IDLE;
                    count_reg <= '0;
                end
            end
        end
    end

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_stop |-> !busy)
        else $error("block still busy after final stop");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_stop |-> busy)
        else $error("block idle before final stop");

    a_sum_grows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> total_movement >= dhs_pkg::SUM_W'(seek_distance))
        else $error("running movement below seek distance");

    a_turn_down: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && is_turnaround && !dir_reg |-> served_cylinder == '0)
        else $error("downward turnaround not at cylinder zero");

endmodule

// File: bench/disk_head_scheduler_tb.sv
`timescale 1ns / 1ps

module disk_head_scheduler_tb;

    localparam int MAX_REQ = 63;
    localparam int LIMIT_CYCLES = 3000000;
    localparam logic [1:0] ALG_UNUSED = 2'd3;

    typedef enum logic { ROW_CFG, ROW_REQ } row_kind_e;

    typedef struct packed {
        logic [dhs_pkg::CYL_W-1:0] cyl;
        logic [dhs_pkg::CYL_W-1:0] seek;
        logic [dhs_pkg::SUM_W-1:0] total;
        logic                      turn;
        logic                      last;
    } stop_t;

    typedef struct packed {
        row_kind_e                  kind;
        logic [dhs_pkg::CIDX_W-1:0] idx;
        logic [dhs_pkg::DC_W-1:0]   data;
        logic                       last;
        logic                       chk;
        stop_t                      want;
    } row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [dhs_pkg::CYL_W-1:0] cylinder;
    logic last_request;
    logic cfg_valid;
    logic cfg_ready;
    logic [dhs_pkg::CIDX_W-1:0] cfg_index;
    logic [dhs_pkg::DC_W-1:0] cfg_data;
    logic result_valid;
    logic [dhs_pkg::CYL_W-1:0] served_cylinder;
    logic [dhs_pkg::CYL_W-1:0] seek_distance;
    logic [dhs_pkg::SUM_W-1:0] total_movement;
    logic is_turnaround;
    logic last_stop;

    disk_head_scheduler dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cylinder(cylinder), .last_request(last_request),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result_valid(result_valid), .served_cylinder(served_cylinder),
        .seek_distance(seek_distance), .total_movement(total_movement),
        .is_turnaround(is_turnaround), .last_stop(last_stop)
    );

    // scheduler copy
    logic [1:0]                alg_r;
    logic [dhs_pkg::CYL_W-1:0] head_start_r;
    logic [dhs_pkg::DC_W-1:0]  ncyl_r;
    logic                      dir_r;
    logic [dhs_pkg::CYL_W-1:0] pending_reqs[$];
    logic [dhs_pkg::CYL_W-1:0] arm;
    logic [22:0]               msum;

    stop_t stops_due[$];
    stop_t batch_stops[$];
    row_t  rows[$];
    int    errors = 0;
    int    cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [dhs_pkg::CYL_W-1:0] gap_of(logic [dhs_pkg::CYL_W-1:0] a,
                                                         logic [dhs_pkg::CYL_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic void add_stop(logic [dhs_pkg::CYL_W-1:0] target, logic turn);
        stop_t s;
        s.seek  = gap_of(target, arm);
        msum    = msum + 23'(s.seek);
        arm     = target;
        s.cyl   = target;
        s.total = msum[dhs_pkg::SUM_W-1:0];
        s.turn  = turn;
        s.last  = 1'b0;
        batch_stops.insert(batch_stops.size(), s);
    endfunction

    function automatic logic [dhs_pkg::CYL_W-1:0] disk_top();
        if (ncyl_r == 0)
            return '0;
        if (ncyl_r - 1 > 17'h0FFFF)
            return 16'hFFFF;
        return dhs_pkg::CYL_W'(ncyl_r - 1);
    endfunction

    function automatic void plan_batch();
        logic [dhs_pkg::CYL_W-1:0] s[$];
        bit done[MAX_REQ];
        int n, up, best;
        logic [dhs_pkg::CYL_W-1:0] bestd;
        n = pending_reqs.size();
        arm = head_start_r;
        msum = '0;
        batch_stops.delete();
        if (alg_r == dhs_pkg::ALG_SCAN)
        begin
            s = pending_reqs;
            s.sort();
            up = n;
            for (int i = 0; i < n; i++)
                if (s[i] > arm)
                begin
                    up = i;
                    break;
                end
            if (dir_r)
            begin
                for (int i = up; i < n; i++) add_stop(s[i], 1'b0);
                add_stop(disk_top(), 1'b1);
                for (int i = up; i > 0; i--) add_stop(s[i-1], 1'b0);
            end
            else
            begin
                for (int i = up; i > 0; i--) add_stop(s[i-1], 1'b0);
                add_stop('0, 1'b1);
                for (int i = up; i < n; i++) add_stop(s[i], 1'b0);
            end
        end
        else if (alg_r == dhs_pkg::ALG_SSTF)
        begin
            for (int i = 0; i < MAX_REQ; i++) done[i] = 0;
            for (int i = 0; i < n; i++)
            begin
                best = -1;
                bestd = '0;
                for (int j = 0; j < n; j++)
                    if (!done[j] && (best < 0 || gap_of(pending_reqs[j], arm) < bestd))
                    begin
                        best = j;
                        bestd = gap_of(pending_reqs[j], arm);
                    end
                done[best] = 1;
                add_stop(pending_reqs[best], 1'b0);
            end
        end
        else
            foreach (pending_reqs[i]) add_stop(pending_reqs[i], 1'b0);
        if (batch_stops.size() > 0)
            batch_stops[batch_stops.size()-1].last = 1'b1;
        pending_reqs.delete();
    endfunction

    always @(posedge clk)
    begin
        stop_t want;
        if (rst_n && result_valid)
        begin
            if (stops_due.size() == 0)
            begin
                $error("unexpected stop: cylinder %0d", served_cylinder);
                errors++;
            end
            else
            begin
                want = stops_due.pop_front();
                if (served_cylinder !== want.cyl)
                begin
                    $error("served_cylinder: expected %0d, got %0d", want.cyl, served_cylinder);
                    errors++;
                end
                if (seek_distance !== want.seek)
                begin
                    $error("seek_distance: expected %0d, got %0d", want.seek, seek_distance);
                    errors++;
                end
                if (total_movement !== want.total)
                begin
                    $error("total_movement: expected %0d, got %0d", want.total, total_movement);
                    errors++;
                end
                if (is_turnaround !== want.turn)
                begin
                    $error("is_turnaround: expected %0d, got %0d", want.turn, is_turnaround);
                    errors++;
                end
                if (last_stop !== want.last)
                begin
                    $error("last_stop: expected %0d, got %0d", want.last, last_stop);
                    errors++;
                end
            end
        end
    end

    // drop start so a held item is not taken again
    task automatic wait_idle();
        start <= 1'b0;
        while (stops_due.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [dhs_pkg::CIDX_W-1:0] idx, logic [dhs_pkg::DC_W-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            dhs_pkg::REG_ALGORITHM:  alg_r = val[1:0];
            dhs_pkg::REG_START_HEAD: head_start_r = val[dhs_pkg::CYL_W-1:0];
            dhs_pkg::REG_DISK_CYL:   ncyl_r = val;
            dhs_pkg::REG_SCAN_DIR:   dir_r = val[0];
            default: ;
        endcase
    endtask

    // chk: the single stop of this batch is typed in by hand
    task automatic send_req(logic [dhs_pkg::CYL_W-1:0] cyl, logic last, int gap, logic chk,
                            stop_t want);
        start        <= 1'b1;
        cylinder     <= cyl;
        last_request <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (pending_reqs.size() < MAX_REQ)
            pending_reqs.insert(pending_reqs.size(), cyl);
        if (last)
        begin
            plan_batch();
            if (chk)
            begin
                batch_stops.delete();
                batch_stops.insert(0, want);
            end
            foreach (batch_stops[i]) stops_due.insert(stops_due.size(), batch_stops[i]);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic void add_row(row_t r);
        rows.insert(rows.size(), r);
    endfunction

    function automatic row_t r_cfg(logic [dhs_pkg::CIDX_W-1:0] idx,
                                   logic [dhs_pkg::DC_W-1:0] val);
        row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = val;
        return r;
    endfunction

    function automatic row_t r_req(logic [dhs_pkg::CYL_W-1:0] cyl, logic last);
        row_t r;
        r = '0;
        r.kind = ROW_REQ;
        r.data = dhs_pkg::DC_W'(cyl);
        r.last = last;
        return r;
    endfunction

    function automatic row_t r_chk(logic [dhs_pkg::CYL_W-1:0] cyl,
                                   logic [dhs_pkg::CYL_W-1:0] seek,
                                   logic [dhs_pkg::SUM_W-1:0] tot);
        row_t r;
        r = r_req(cyl, 1'b1);
        r.chk  = 1'b1;
        r.want = '{cyl, seek, tot, 1'b0, 1'b1};
        return r;
    endfunction

    function automatic logic [dhs_pkg::CYL_W-1:0] rand_cyl(int mode);
        case (mode)
            0: return dhs_pkg::CYL_W'($urandom);
            1: return dhs_pkg::CYL_W'($urandom_range(0, 199));
            2: return dhs_pkg::CYL_W'(100 + $urandom_range(0, 8));
            default: return ($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    initial
    begin
        int sent, bl, mode, gap, calm;
        bit big_done;
        logic [dhs_pkg::DC_W-1:0] nc;
        start = 1'b0;
        cylinder = '0;
        last_request = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        alg_r = dhs_pkg::ALG_FCFS;
        head_start_r = '0;
        ncyl_r = 17'd200;
        dir_r = 1'b1;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(r_chk(16'd100, 16'd100, 22'd100));
        add_row(r_chk(16'hFFFF, 16'hFFFF, 22'd65535));
        add_row(r_chk(16'd0, 16'd0, 22'd0));
        add_row(r_cfg(dhs_pkg::REG_ALGORITHM, dhs_pkg::DC_W'(dhs_pkg::ALG_SSTF)));
        add_row(r_cfg(dhs_pkg::REG_START_HEAD, 17'd50));
        add_row(r_req(16'd40, 1'b0));
        add_row(r_req(16'd60, 1'b0));
        add_row(r_req(16'd55, 1'b1));
        // equal distance: earlier arrival first
        add_row(r_req(16'd40, 1'b0));
        add_row(r_req(16'd60, 1'b1));
        add_row(r_cfg(dhs_pkg::REG_ALGORITHM, dhs_pkg::DC_W'(dhs_pkg::ALG_SCAN)));
        add_row(r_req(16'd10, 1'b0));
        add_row(r_req(16'd150, 1'b1));
        // head above every request
        add_row(r_cfg(dhs_pkg::REG_START_HEAD, 17'hFFFF));
        add_row(r_req(16'd5, 1'b1));
        add_row(r_cfg(dhs_pkg::REG_SCAN_DIR, 17'd0));
        add_row(r_req(16'd300, 1'b0));
        add_row(r_req(16'd7, 1'b1));
        add_row(r_cfg(dhs_pkg::REG_DISK_CYL, 17'd0));
        add_row(r_cfg(dhs_pkg::REG_SCAN_DIR, 17'd1));
        add_row(r_req(16'd9, 1'b1));
        add_row(r_cfg(dhs_pkg::REG_DISK_CYL, 17'h10000));
        add_row(r_cfg(dhs_pkg::REG_START_HEAD, 17'd0));
        add_row(r_req(16'hFFFF, 1'b1));
        add_row(r_cfg(dhs_pkg::REG_DISK_CYL, 17'd1));
        add_row(r_req(16'd3, 1'b1));
        add_row(r_cfg(dhs_pkg::REG_ALGORITHM, dhs_pkg::DC_W'(ALG_UNUSED)));
        add_row(r_req(16'd20, 1'b0));
        add_row(r_req(16'd10, 1'b1));
        add_row(r_cfg(dhs_pkg::REG_DISK_CYL, 17'd200));

        foreach (rows[i])
            if (rows[i].kind == ROW_CFG)
                write_reg(rows[i].idx, rows[i].data);
            else
                send_req(rows[i].data[dhs_pkg::CYL_W-1:0], rows[i].last,
                         $urandom_range(0, 3), rows[i].chk, rows[i].want);

        sent = 0;
        calm = 0;
        big_done = 1'b0;
        while (sent < 420)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                write_reg(dhs_pkg::REG_ALGORITHM, dhs_pkg::DC_W'($urandom_range(0, 3)));
                write_reg(dhs_pkg::REG_START_HEAD, ($urandom_range(0, 3) == 0) ?
                          dhs_pkg::DC_W'(rand_cyl(3)) : dhs_pkg::DC_W'($urandom_range(0, 199)));
                case ($urandom_range(0, 4))
                    0: nc = dhs_pkg::DC_W'($urandom);
                    1: nc = 17'h10000;
                    2: nc = dhs_pkg::DC_W'($urandom_range(0, 1));
                    default: nc = 17'd200;
                endcase
                write_reg(dhs_pkg::REG_DISK_CYL, nc);
                write_reg(dhs_pkg::REG_SCAN_DIR, dhs_pkg::DC_W'($urandom_range(0, 1)));
            end
            // one overfull batch; mostly short ones
            if (!big_done && sent > 150)
            begin
                bl = 70;
                big_done = 1'b1;
            end
            else if ($urandom_range(0, 7) == 0)
                bl = $urandom_range(9, 24);
            else
                bl = $urandom_range(1, 8);
            mode = $urandom_range(0, 3);
            calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < bl; k++)
            begin
                gap = calm ? 0 : $urandom_range(0, 11);
                send_req(rand_cyl(($urandom_range(0, 4) == 0) ? 3 : mode), k == bl - 1,
                         gap, 1'b0, '0);
                sent++;
            end
        end
        start <= 1'b0;

        while (stops_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && stops_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
